// ===== sv/assert_macros.svh =====
// Assertion helpers used by the RTL. They compile away for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define STPP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("stpp assertion failed");

// Expression must never be true outside reset.
`define STPP_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("stpp forbidden condition seen");

`else

`define STPP_ASSERT(label, clk, rst_n, prop)
`define STPP_NEVER(label, clk, rst_n, expr)

`endif

`endif

// ===== sv/stpp_pkg.sv =====
package stpp_pkg;

  // Image size that sets the reset frame width and height.
  localparam int IMAGE_DIM = 256;

  // Fixed-point constants of the sine series.
  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint          ONE_Q30 = 64'sd1073741824;

  // Pipeline layout: entry stage, square stage, sum stage, root stages,
  // reciprocal multiply stage and the output register.
  localparam int SQRT_STG  = 9;
  localparam int SQRT_FST  = 3;
  localparam int MUL_STG   = SQRT_FST + SQRT_STG;
  localparam int NUM_STG   = MUL_STG + 2;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_PERIOD = 3'd1;
  localparam logic [2:0] REG_ANGLE  = 3'd2;
  localparam logic [2:0] REG_WIDTH  = 3'd3;
  localparam logic [2:0] REG_HEIGHT = 3'd4;

  // Pattern mode codes.
  localparam logic MODE_LINE   = 1'b0;
  localparam logic MODE_CIRCLE = 1'b1;

  typedef logic [15:0] deg_tab_t [91];
  typedef logic [7:0]  val_tab_t [256];
  typedef logic [27:0] rcp_tab_t [256];

  // Settings that the pipeline reads; keep static while items are in flight (not enforced).
  typedef struct packed {
    logic               mode;
    logic signed [16:0] s15;
    logic signed [16:0] c15;
    logic [27:0]        recip;
    logic [7:0]         cx;
    logic [7:0]         cy;
  } cfg_t;

  // Partial remainder and root of the digit-by-digit square root.
  typedef struct packed {
    logic [19:0] rem;
    logic [17:0] root;
  } sqrt_st_t;

  // Eight-term sine series in Q30 over one quarter wave, clamped to [0, 1].
  function automatic longint taylor_q30(longint unsigned x);
    longint unsigned term;
    longint          sum;
    term = x;
    sum  = longint'(x);
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 6;
    sum  = sum - longint'(term);
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 20;
    sum  = sum + longint'(term);
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 42;
    sum  = sum - longint'(term);
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 72;
    sum  = sum + longint'(term);
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 110;
    sum  = sum - longint'(term);
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 156;
    sum  = sum + longint'(term);
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 210;
    sum  = sum - longint'(term);
    if (sum < 0) sum = 0;
    if (sum > ONE_Q30) sum = ONE_Q30;
    return sum;
  endfunction

  // Q1.15 sine of whole degrees 0..90, rounded half up.
  function automatic deg_tab_t build_deg_tab();
    deg_tab_t t;
    longint   v;
    for (int a = 0; a < 91; a++) begin
      if (a == 0) begin
        v = 0;
      end else if (a == 90) begin
        v = ONE_Q30;
      end else begin
        v = taylor_q30((PI_Q30 * longint'(a)) / 180);
      end
      t[a] = 16'((v + 16384) >>> 15);
    end
    return t;
  endfunction

  // Grey level for a cosine of +s or -s, s the quarter-wave sine of a/256.
  function automatic val_tab_t build_val_tab(bit negative);
    val_tab_t t;
    longint   s;
    for (int a = 0; a < 256; a++) begin
      if (a == 0) begin
        s = 0;
      end else begin
        s = taylor_q30((PI_Q30 * longint'(a)) / 512);
      end
      if (negative) begin
        t[a] = 8'((255 * (ONE_Q30 - s)) >>> 31);
      end else begin
        t[a] = 8'((255 * (ONE_Q30 + s)) >>> 31);
      end
    end
    return t;
  endfunction

  // ceil(2^27 / p) by long division; a period of zero counts as one.
  function automatic rcp_tab_t build_rcp_tab();
    rcp_tab_t    t;
    logic [35:0] num;
    logic [35:0] rem;
    logic [27:0] q;
    logic [7:0]  p;
    for (int i = 0; i < 256; i++) begin
      p   = (i == 0) ? 8'd1 : 8'(i);
      num = (36'd1 << 27) + 36'(p) - 36'd1;
      rem = '0;
      q   = '0;
      for (int b = 35; b >= 0; b--) begin
        rem = {rem[34:0], num[b]};
        q   = {q[26:0], (rem >= 36'(p))};
        if (rem >= 36'(p)) rem = rem - 36'(p);
      end
      t[i] = q;
    end
    return t;
  endfunction

  localparam deg_tab_t DEG_TAB  = build_deg_tab();
  localparam val_tab_t VPOS_TAB = build_val_tab(1'b0);
  localparam val_tab_t VNEG_TAB = build_val_tab(1'b1);
  localparam rcp_tab_t RCP_TAB  = build_rcp_tab();

  // One root bit per step: one step per radicand bit pair.
  function automatic sqrt_st_t sqrt_step(sqrt_st_t s, logic [1:0] d);
    sqrt_st_t    o;
    logic [19:0] rem_sh;
    logic [19:0] trial;
    rem_sh = {s.rem[17:0], d};
    trial  = {s.root, 2'b01};
    if (rem_sh >= trial) begin
      o.rem  = rem_sh - trial;
      o.root = {s.root[16:0], 1'b1};
    end else begin
      o.rem  = rem_sh;
      o.root = {s.root[16:0], 1'b0};
    end
    return o;
  endfunction

endpackage

// ===== sv/sinusoidal_test_pattern_pixel.sv =====
// Channel   Handshake                Payload
// in_       in_valid / in_ready      in_pixel_x[7:0], in_pixel_y[7:0]
// out_      out_valid / out_ready    out_pixel_value[7:0]
// APB       psel, penable, pwrite    paddr[4:0], pwdata[31:0], prdata[31:0]
//
// One pixel enters per clock while the output does not stall; each pixel passes
// fourteen register stages, the nine square-root stages plus five others, the
// last of them being the output register.
// rst_n is synchronous: it empties the pipeline and loads register defaults.
// A stall on the output fills the empty stages first and then holds in_ready
// low; nothing is dropped or repeated.
// Angle settings pass quad_r/off_r and s15_r/c15_r; period passes recip_r.
module sinusoidal_test_pattern_pixel
  import stpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_pixel_x,
  input  logic [7:0]  in_pixel_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_pixel_value,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [8:0] FRAME_RST = 9'(IMAGE_DIM);

  logic       mode_r;
  logic [7:0] period_r;
  logic [8:0] angle_r;
  logic [8:0] width_r;
  logic [8:0] height_r;
  logic       wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_LINE;
      period_r <= 8'd4;
      angle_r  <= 9'd0;
      width_r  <= FRAME_RST;
      height_r <= FRAME_RST;
    end else if (wr) begin
      case (paddr[4:2])
        REG_MODE:   mode_r   <= pwdata[0];
        REG_PERIOD: period_r <= pwdata[7:0];
        REG_ANGLE:  angle_r  <= pwdata[8:0];
        REG_WIDTH:  width_r  <= pwdata[8:0];
        REG_HEIGHT: height_r <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    case (paddr[4:2])
      REG_MODE:   prdata = {31'd0, mode_r};
      REG_PERIOD: prdata = {24'd0, period_r};
      REG_ANGLE:  prdata = {23'd0, angle_r};
      REG_WIDTH:  prdata = {23'd0, width_r};
      REG_HEIGHT: prdata = {23'd0, height_r};
      default:    prdata = 32'd0;
    endcase
  end

  // Angle reduced to a quadrant and an offset of 0..89 degrees.
  logic [8:0] deg;
  logic [1:0] quad;
  logic [6:0] off;
  logic [1:0] quad_r;
  logic [6:0] off_r;

  always_comb begin
    deg = (angle_r >= 9'd360) ? angle_r - 9'd360 : angle_r;
    if (deg < 9'd90) begin
      quad = 2'd0;
      off  = deg[6:0];
    end else if (deg < 9'd180) begin
      quad = 2'd1;
      off  = 7'(deg - 9'd90);
    end else if (deg < 9'd270) begin
      quad = 2'd2;
      off  = 7'(deg - 9'd180);
    end else begin
      quad = 2'd3;
      off  = 7'(deg - 9'd270);
    end
  end

  // Sine and cosine from the degree table by quadrant symmetry.
  logic signed [16:0] tab_a, tab_b;
  logic signed [16:0] s15_nxt, c15_nxt;
  logic signed [16:0] s15_r, c15_r;
  logic [27:0]        recip_r;

  always_comb begin
    tab_a = $signed({1'b0, DEG_TAB[off_r]});
    tab_b = $signed({1'b0, DEG_TAB[7'(7'd90 - off_r)]});
    case (quad_r)
      2'd0: begin
        s15_nxt = tab_a;
        c15_nxt = tab_b;
      end
      2'd1: begin
        s15_nxt = tab_b;
        c15_nxt = -tab_a;
      end
      2'd2: begin
        s15_nxt = -tab_a;
        c15_nxt = -tab_b;
      end
      default: begin
        s15_nxt = -tab_b;
        c15_nxt = tab_a;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quad_r  <= 2'd0;
      off_r   <= 7'd0;
      s15_r   <= 17'sd0;
      c15_r   <= 17'sd32768;
      recip_r <= RCP_TAB[4];
    end else begin
      quad_r  <= quad;
      off_r   <= off;
      s15_r   <= s15_nxt;
      c15_r   <= c15_nxt;
      recip_r <= RCP_TAB[period_r];
    end
  end

  cfg_t cfg;

  always_comb begin
    cfg.mode  = mode_r;
    cfg.s15   = s15_r;
    cfg.c15   = c15_r;
    cfg.recip = recip_r;
    cfg.cx    = width_r[8:1];
    cfg.cy    = height_r[8:1];
  end

  stpp_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pixel_x      (in_pixel_x),
    .in_pixel_y      (in_pixel_y),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_value (out_pixel_value)
  );

endmodule

// ===== sv/stpp_core.sv =====
`include "assert_macros.svh"

module stpp_core
  import stpp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_pixel_x,
  input  logic [7:0] in_pixel_y,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_pixel_value
);

  logic [NUM_STG-1:0] vld_r;
  logic [NUM_STG-1:0] vld_nxt;
  logic [NUM_STG-1:0] en;

  // A stage loads when it is empty or when the stage after it moves.
  always_comb begin
    en[NUM_STG-1] = !vld_r[NUM_STG-1] || out_ready;
    for (int i = NUM_STG - 2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
    vld_nxt = (en & {vld_r[NUM_STG-2:0], in_valid}) | (~en & vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[NUM_STG-1];

  // Entry stage: offsets from the circle center.
  logic [7:0]        a_x_r, a_y_r;
  logic signed [8:0] a_dx_r, a_dy_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_x_r  <= in_pixel_x;
      a_y_r  <= in_pixel_y;
      a_dx_r <= $signed({1'b0, cfg.cx}) - $signed({1'b0, in_pixel_x});
      a_dy_r <= $signed({1'b0, cfg.cy}) - $signed({1'b0, in_pixel_y});
    end
  end

  // Squares of the offsets.
  logic [7:0]  b_x_r, b_y_r;
  logic [15:0] b_dx2_r, b_dy2_r;
  logic signed [17:0] dx2, dy2;

  assign dx2 = a_dx_r * a_dx_r;
  assign dy2 = a_dy_r * a_dy_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      b_x_r   <= a_x_r;
      b_y_r   <= a_y_r;
      b_dx2_r <= dx2[15:0];
      b_dy2_r <= dy2[15:0];
    end
  end

  // Squared distance, and the two products of the line projection.
  logic [16:0]        c_sq_r;
  logic signed [25:0] c_pyc_r, c_pxs_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      c_sq_r  <= 17'(b_dx2_r) + 17'(b_dy2_r);
      c_pyc_r <= $signed({1'b0, b_y_r}) * cfg.c15;
      c_pxs_r <= $signed({1'b0, b_x_r}) * cfg.s15;
    end
  end

  // Line phase in 1/1024 pixel, floored. A negative phase is folded to its
  // one's complement so that the divider sees an unsigned value.
  logic signed [26:0] phase;
  logic signed [26:0] phase_sh;
  logic               line_neg;
  logic [18:0]        line_mag;

  always_comb begin
    phase    = 27'(c_pyc_r) - 27'(c_pxs_r);
    phase_sh = phase >>> 5;
    line_neg = phase[26];
    line_mag = line_neg ? ~phase_sh[18:0] : phase_sh[18:0];
  end

  // Square root stages: two result bits per stage, radicand is sq * 2^16.
  sqrt_st_t    s_st_r  [SQRT_STG];
  logic [16:0] s_sq_r  [SQRT_STG];
  logic [18:0] s_mag_r [SQRT_STG];
  logic        s_neg_r [SQRT_STG];

  for (genvar k = 0; k < SQRT_STG; k++) begin : g_sqrt
    sqrt_st_t    st_in;
    sqrt_st_t    st_mid;
    sqrt_st_t    st_out;
    logic [16:0] sq_in;
    logic [18:0] mag_in;
    logic        neg_in;
    logic [35:0] rad;

    if (k == 0) begin : g_first
      always_comb begin
        st_in  = '0;
        sq_in  = c_sq_r;
        mag_in = line_mag;
        neg_in = line_neg;
      end
    end else begin : g_next
      always_comb begin
        st_in  = s_st_r[k-1];
        sq_in  = s_sq_r[k-1];
        mag_in = s_mag_r[k-1];
        neg_in = s_neg_r[k-1];
      end
    end

    always_comb begin
      rad    = {3'b000, sq_in, 16'h0000};
      st_mid = sqrt_step(st_in, rad[35-4*k -: 2]);
      st_out = sqrt_step(st_mid, rad[33-4*k -: 2]);
    end

    always_ff @(posedge clk) begin
      if (en[SQRT_FST+k]) begin
        s_st_r[k]  <= st_out;
        s_sq_r[k]  <= sq_in;
        s_mag_r[k] <= mag_in;
        s_neg_r[k] <= neg_in;
      end
    end
  end

  // Divide by the period: multiply by ceil(2^27 / period), exact for
  // dividends below 2^19. Only the low ten quotient bits are kept.
  logic [18:0] div_num;
  logic [46:0] div_prod;
  logic [9:0]  m_q_r;
  logic        m_neg_r;

  always_comb begin
    if (cfg.mode == MODE_CIRCLE) begin
      div_num = {s_st_r[SQRT_STG-1].root[16:0], 2'b00};
    end else begin
      div_num = s_mag_r[SQRT_STG-1];
    end
    div_prod = 47'(div_num) * 47'(cfg.recip);
  end

  always_ff @(posedge clk) begin
    if (en[MUL_STG]) begin
      m_q_r   <= div_prod[36:27];
      m_neg_r <= (cfg.mode == MODE_LINE) && s_neg_r[SQRT_STG-1];
    end
  end

  // Cycle index to grey level through quarter-wave tables.
  logic [9:0] idx;
  logic [9:0] wav;
  logic [7:0] wr;
  logic [7:0] warg;
  logic [7:0] val;
  logic [7:0] o_val_r;

  always_comb begin
    idx  = m_neg_r ? ~m_q_r : m_q_r;
    wav  = idx + 10'd256;
    wr   = wav[7:0];
    warg = 8'(9'd256 - {1'b0, wr});
    case (wav[9:8])
      2'd0: val = VPOS_TAB[wr];
      2'd1: val = (wr == 8'd0) ? 8'd255 : VPOS_TAB[warg];
      2'd2: val = VNEG_TAB[wr];
      2'd3: val = (wr == 8'd0) ? 8'd0 : VNEG_TAB[warg];
      default: val = VPOS_TAB[wr];
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[NUM_STG-1]) begin
      o_val_r <= val;
    end
  end

  assign out_pixel_value = o_val_r;

  // A blocked input means every stage holds an item.
  `STPP_ASSERT(a_full_when_blocked, clk, rst_n, !in_ready |-> (&vld_r))
  // An accepted transfer occupies the entry stage on the next cycle.
  `STPP_ASSERT(a_entry_loaded, clk, rst_n, (in_valid && in_ready) |=> vld_r[0])
  // The distance root never reaches the bit that the divider drops.
  `STPP_NEVER(a_root_range, clk, rst_n,
              vld_r[MUL_STG-1] && s_st_r[SQRT_STG-1].root[17])

endmodule

// ===== tb/testbench.sv =====
module testbench;
  import stpp_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_pixel_x;
  logic [7:0]  in_pixel_y;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_pixel_value;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sinusoidal_test_pattern_pixel dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_pixel_x(in_pixel_x), .in_pixel_y(in_pixel_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pixel_value(out_pixel_value),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Model copy of the settings registers.
  logic       mdl_mode;
  logic [7:0] mdl_period;
  logic [8:0] mdl_angle;
  logic [8:0] mdl_width;
  logic [8:0] mdl_height;

  logic [7:0] grey_q[$];
  bit         failed;
  int         snd_idle;
  int         rcv_stall;

  typedef struct {
    logic [7:0] x;
    logic [7:0] y;
    bit         known;
    logic [7:0] grey;
  } pix_row_t;

  typedef struct {
    logic       mode;
    logic [7:0] period;
    logic [8:0] angle;
    logic [8:0] width;
    logic [8:0] height;
  } setting_t;

  // Sine of a quarter-wave fraction num/den in Q30 by an eight-term series.
  function automatic longint quarter_sine(longint unsigned num, longint unsigned den);
    longint unsigned ang;
    longint unsigned term;
    longint          sum;
    if (num == 0) return 0;
    if (num >= den) return ONE_Q30;
    ang  = (PI_Q30 * num) / (2 * den);
    term = ang;
    sum  = longint'(ang);
    for (int k = 1; k <= 7; k++) begin
      term = (term * ang) >> 30;
      term = (term * ang) >> 30;
      term = term / ((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > ONE_Q30) sum = ONE_Q30;
    return sum;
  endfunction

  // Sine over a full turn of four quarters.
  function automatic longint full_sine(longint unsigned pos, longint unsigned quarter);
    longint unsigned q;
    longint unsigned r;
    q = (pos / quarter) & 3;
    r = pos % quarter;
    case (q)
      0: return quarter_sine(r, quarter);
      1: return quarter_sine(quarter - r, quarter);
      2: return -quarter_sine(r, quarter);
      default: return -quarter_sine(quarter - r, quarter);
    endcase
  endfunction

  function automatic longint to_q15(longint v);
    if (v >= 0) return (v + 16384) / 32768;
    return -((-v + 16384) / 32768);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Grey level of one pixel under the current settings.
  function automatic logic [7:0] grey_level(logic [7:0] px, logic [7:0] py);
    longint unsigned per;
    longint unsigned idx;
    longint unsigned deg;
    longint unsigned u;
    longint          s15;
    longint          c15;
    longint          phase;
    longint          dx;
    longint          dy;
    longint          c;
    per = (mdl_period == 0) ? 1 : longint'(mdl_period);
    if (mdl_mode == MODE_LINE) begin
      deg   = mdl_angle % 360;
      s15   = to_q15(full_sine(deg, 90));
      c15   = to_q15(full_sine(deg + 90, 90));
      phase = longint'(py) * c15 - longint'(px) * s15;
      u     = longint'(phase + longint'(per << 25));
      idx   = (u / (per * 32)) & 1023;
    end else begin
      dx  = longint'(mdl_width / 2) - longint'(px);
      dy  = longint'(mdl_height / 2) - longint'(py);
      u   = int_sqrt(longint'(dx * dx + dy * dy) << 16);
      idx = ((u * 4) / per) & 1023;
    end
    c = full_sine((idx + 256) & 1023, 256);
    return 8'((255 * longint'(ONE_Q30 + c)) >>> 31);
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog.
  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Result side: random stalls and comparison with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (grey_q.size() == 0) begin
        $display("%0t: unexpected transfer, actual %0d", $time, out_pixel_value);
        failed = 1'b1;
      end else begin
        if (out_pixel_value !== grey_q[0]) begin
          $display("%0t: pixel_value expected %0d actual %0d", $time, grey_q[0],
                   out_pixel_value);
          failed = 1'b1;
        end
        void'(grey_q.pop_front());
      end
    end
    out_ready <= ($urandom_range(99) >= rcv_stall);
  end

  // One register write: setup phase, access phase, then an idle phase.
  task automatic reg_write(logic [2:0] idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(setting_t s);
    reg_write(REG_MODE, {$urandom} & ~32'h1 | 32'(s.mode));
    reg_write(REG_PERIOD, 32'(s.period));
    reg_write(REG_ANGLE, 32'(s.angle));
    reg_write(REG_WIDTH, 32'(s.width));
    reg_write(REG_HEIGHT, 32'(s.height));
    mdl_mode   = s.mode;
    mdl_period = s.period;
    mdl_angle  = s.angle;
    mdl_width  = s.width;
    mdl_height = s.height;
    // Wait for the settings to reach the pipeline.
    repeat (5) @(posedge clk);
  endtask

  // Present one pixel and hold it until its transfer.
  task automatic send_pixel(logic [7:0] px, logic [7:0] py, bit known, logic [7:0] grey);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_pixel_x <= px;
    in_pixel_y <= py;
    do @(posedge clk); while (!in_ready);
    grey_q.push_back(known ? grey : grey_level(px, py));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (grey_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  pix_row_t pix_rows[] = '{
    // Reset settings: line at angle 0, period 4, so the level follows the row.
    '{8'd0,   8'd0,   1'b1, 8'd255},
    '{8'd0,   8'd1,   1'b1, 8'd127},
    '{8'd0,   8'd2,   1'b1, 8'd0},
    '{8'd0,   8'd3,   1'b1, 8'd127},
    '{8'd255, 8'd0,   1'b1, 8'd255},
    '{8'd255, 8'd255, 1'b1, 8'd127},
    '{8'd0,   8'd255, 1'b1, 8'd127},
    '{8'd255, 8'd2,   1'b1, 8'd0},
    '{8'd128, 8'd128, 1'b0, 8'd0},
    '{8'd85,  8'd170, 1'b0, 8'd0},
    '{8'd170, 8'd85,  1'b0, 8'd0},
    '{8'd1,   8'd254, 1'b0, 8'd0}
  };

  setting_t settings[] = '{
    '{MODE_LINE,   8'd0,   9'd0,   9'd256, 9'd256},  // zero period
    '{MODE_LINE,   8'd255, 9'd359, 9'd256, 9'd256},
    '{MODE_LINE,   8'd1,   9'd511, 9'd1,   9'd1},    // angle past 359
    '{MODE_LINE,   8'd17,  9'd45,  9'd0,   9'd0},
    '{MODE_CIRCLE, 8'd4,   9'd90,  9'd256, 9'd256},
    '{MODE_CIRCLE, 8'd1,   9'd0,   9'd0,   9'd1},    // center at the origin
    '{MODE_CIRCLE, 8'd255, 9'd180, 9'd511, 9'd511},
    '{MODE_CIRCLE, 8'd0,   9'd400, 9'd100, 9'd37}
  };

  // Stimulus.
  initial begin
    setting_t s;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_pixel_x <= '0;
    in_pixel_y <= '0;
    out_ready  <= 1'b0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    failed     = 1'b0;
    snd_idle   = 0;
    rcv_stall  = 0;
    mdl_mode   = MODE_LINE;
    mdl_period = 8'd4;
    mdl_angle  = 9'd0;
    mdl_width  = 9'(IMAGE_DIM);
    mdl_height = 9'(IMAGE_DIM);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pixels under the reset settings.
    foreach (pix_rows[i]) send_pixel(pix_rows[i].x, pix_rows[i].y, pix_rows[i].known,
                                     pix_rows[i].grey);
    drain();

    // Random pixels over fixed and random settings, cycling idle patterns.
    for (int p = 0; p < 12; p++) begin
      if (p < settings.size()) begin
        s = settings[p];
      end else begin
        s.mode   = 1'($urandom_range(1));
        s.period = 8'($urandom_range(255));
        s.angle  = 9'($urandom_range(511));
        s.width  = 9'($urandom_range(511));
        s.height = 9'($urandom_range(511));
      end
      apply_setting(s);
      case (p % 4)
        0: begin snd_idle = 0;  rcv_stall = 0;  end
        1: begin snd_idle = 65; rcv_stall = 0;  end
        2: begin snd_idle = 0;  rcv_stall = 65; end
        default: begin snd_idle = 24; rcv_stall = 24; end
      endcase
      for (int n = 0; n < 40; n++) send_pixel(8'($urandom_range(255)),
                                              8'($urandom_range(255)), 1'b0, 8'd0);
      snd_idle  = 0;
      rcv_stall = 0;
      drain();
    end

    if (!failed) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
